// ----- rtl/nlau_pkg.sv -----
package nlau_pkg;

   localparam int VALUE_WIDTH        = 32;
   localparam int MAX_POINTS_DEFAULT = 8;
   localparam int NUM_SURF           = 4;
   localparam int SURF_W             = 2;
   localparam int REQ_W              = 3;
   localparam int SENSE_W            = 2;
   localparam int IDX_FIELD_W        = 3;
   localparam int CNT_FIELD_W        = 4;
   localparam int CSR_IDX_W          = 1;
   localparam int OP_W               = 3;

   localparam int FRAC_W      = 32;
   localparam int FRAC_SHIFT  = 16;
   localparam int DIFF_W      = VALUE_WIDTH + 1;
   localparam int NUM_W       = DIFF_W + FRAC_SHIFT;
   localparam int DEN_W       = DIFF_W;
   localparam int PROD_W      = FRAC_W + DIFF_W;
   localparam int WIDE_W      = PROD_W - FRAC_SHIFT + 1;

   localparam logic [CNT_FIELD_W-1:0] PTS_RESET = CNT_FIELD_W'(8);
   localparam int PTS_MIN = 2;

   localparam logic [REQ_W-1:0] REQ_WR_SLEW = 3'd0;
   localparam logic [REQ_W-1:0] REQ_WR_LOAD = 3'd1;
   localparam logic [REQ_W-1:0] REQ_WR_GRID = 3'd2;
   localparam logic [REQ_W-1:0] REQ_START   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_EVAL    = 3'd4;

   localparam logic [SENSE_W-1:0] SENSE_POS = 2'd0;
   localparam logic [SENSE_W-1:0] SENSE_NEG = 2'd1;
   localparam logic [SENSE_W-1:0] SENSE_NON = 2'd2;

   localparam logic [OP_W-1:0] OP_NOP     = 3'd0;
   localparam logic [OP_W-1:0] OP_WR_SLEW = 3'd1;
   localparam logic [OP_W-1:0] OP_WR_LOAD = 3'd2;
   localparam logic [OP_W-1:0] OP_WR_GRID = 3'd3;
   localparam logic [OP_W-1:0] OP_START   = 3'd4;
   localparam logic [OP_W-1:0] OP_EVAL    = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_POINTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_POINTS = 1'b1;

   typedef logic signed [VALUE_WIDTH-1:0] val_type;
   typedef logic signed [FRAC_W-1:0]      frac_type;

   localparam frac_type FRAC_MAX = {1'b0, {(FRAC_W-1){1'b1}}};
   localparam frac_type FRAC_MIN = {1'b1, {(FRAC_W-1){1'b0}}};

   localparam logic signed [WIDE_W-1:0] VAL_MAX_W =
      {{(WIDE_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] VAL_MIN_W =
      {{(WIDE_W-VALUE_WIDTH+1){1'b1}}, {(VALUE_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic [OP_W-1:0]        op;
      logic [SURF_W-1:0]      surf;
      logic [IDX_FIELD_W-1:0] row;
      logic [IDX_FIELD_W-1:0] col;
      val_type                wval;
      logic [SENSE_W-1:0]     sense;
      val_type                arr_rise;
      val_type                arr_fall;
      val_type                slew_rise;
      val_type                slew_fall;
      val_type                load_rise;
      val_type                load_fall;
   } cmd_type;

   typedef struct packed {
      val_type arr_rise;
      val_type arr_fall;
      val_type slew_rise;
      val_type slew_fall;
      logic    sat;
   } rsp_type;

   // clamp to the value range, flag in the top bit
   function automatic logic [VALUE_WIDTH:0] sat_wide(input logic signed [WIDE_W-1:0] v);
      logic [VALUE_WIDTH:0] r;
      if (v > VAL_MAX_W) begin
         r = {1'b1, VAL_MAX_W[VALUE_WIDTH-1:0]};
      end else if (v < VAL_MIN_W) begin
         r = {1'b1, VAL_MIN_W[VALUE_WIDTH-1:0]};
      end else begin
         r = {1'b0, v[VALUE_WIDTH-1:0]};
      end
      return r;
   endfunction

endpackage

// ----- rtl/nlau_ifs.sv -----
interface nlau_req_if;
   import nlau_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [REQ_W-1:0]       req_type;
   logic [SURF_W-1:0]      surface_sel;
   logic [IDX_FIELD_W-1:0] row;
   logic [IDX_FIELD_W-1:0] col;
   val_type                write_value;
   logic [SENSE_W-1:0]     arc_sense;
   val_type                arrival_in_rise;
   val_type                arrival_in_fall;
   val_type                slew_in_rise;
   val_type                slew_in_fall;
   val_type                load_rise;
   val_type                load_fall;

   modport source (output valid, req_type, surface_sel, row, col, write_value, arc_sense,
                   arrival_in_rise, arrival_in_fall, slew_in_rise, slew_in_fall,
                   load_rise, load_fall, input ready);
   modport sink (input valid, req_type, surface_sel, row, col, write_value, arc_sense,
                 arrival_in_rise, arrival_in_fall, slew_in_rise, slew_in_fall,
                 load_rise, load_fall, output ready);
endinterface

interface nlau_rsp_if;
   import nlau_pkg::*;
   logic    valid;
   logic    ready;
   val_type arrival_out_rise;
   val_type arrival_out_fall;
   val_type slew_out_rise;
   val_type slew_out_fall;
   logic    saturated;

   modport source (output valid, arrival_out_rise, arrival_out_fall, slew_out_rise,
                   slew_out_fall, saturated, input ready);
   modport sink (input valid, arrival_out_rise, arrival_out_fall, slew_out_rise,
                 slew_out_fall, saturated, output ready);
endinterface

interface nlau_csr_if;
   import nlau_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   addr;
   logic [CNT_FIELD_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/nlau_ram.sv -----
module nlau_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/nlau_front.sv -----
module nlau_front #(
   parameter int MAX_POINTS = nlau_pkg::MAX_POINTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   nlau_req_if.sink          req_chan,
   output logic              cmd_valid,
   output nlau_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import nlau_pkg::*;

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   cmd_type            q_ff [QDEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   cmd_type            cls;
   logic               row_ok, col_ok, sense_ok, push;

   always_comb begin
      row_ok   = int'(req_chan.row) < MAX_POINTS;
      col_ok   = int'(req_chan.col) < MAX_POINTS;
      sense_ok = (req_chan.arc_sense == SENSE_POS) || (req_chan.arc_sense == SENSE_NEG) ||
                 (req_chan.arc_sense == SENSE_NON);
      cls.surf      = req_chan.surface_sel;
      cls.row       = req_chan.row;
      cls.col       = req_chan.col;
      cls.wval      = req_chan.write_value;
      cls.sense     = req_chan.arc_sense;
      cls.arr_rise  = req_chan.arrival_in_rise;
      cls.arr_fall  = req_chan.arrival_in_fall;
      cls.slew_rise = req_chan.slew_in_rise;
      cls.slew_fall = req_chan.slew_in_fall;
      cls.load_rise = req_chan.load_rise;
      cls.load_fall = req_chan.load_fall;
      unique case (req_chan.req_type)
         REQ_WR_SLEW: cls.op = row_ok ? OP_WR_SLEW : OP_NOP;
         REQ_WR_LOAD: cls.op = col_ok ? OP_WR_LOAD : OP_NOP;
         REQ_WR_GRID: cls.op = (row_ok && col_ok) ? OP_WR_GRID : OP_NOP;
         REQ_START:   cls.op = OP_START;
         REQ_EVAL:    cls.op = sense_ok ? OP_EVAL : OP_NOP;
         default:     cls.op = OP_NOP;
      endcase
   end

   assign req_chan.ready = count_ff != QCNT_W'(QDEPTH);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = count_ff != '0;
   assign cmd            = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end
endmodule

// ----- rtl/nlau_div.sv -----
module nlau_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       neg,
   input  logic [nlau_pkg::NUM_W-1:0] num_mag,
   input  logic [nlau_pkg::DEN_W-1:0] den_mag,
   output logic                       done,
   output nlau_pkg::frac_type         quot,
   output logic                       sat
);
   import nlau_pkg::*;

   localparam int REM_W = DEN_W + 1;
   localparam int CW    = $clog2(NUM_W);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0] rem_ff, rem_in, rem_sh;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic             ge, hi;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-2:0], quo_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num_mag;
         rem_in  = '0;
         den_in  = den_mag;
         neg_in  = neg;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      hi = |quo_ff[NUM_W-1:FRAC_W];
      if (neg_ff) begin
         sat  = hi || (quo_ff[FRAC_W-1] && (|quo_ff[FRAC_W-2:0]));
         quot = sat ? FRAC_MIN : frac_type'(-quo_ff[FRAC_W-1:0]);
      end else begin
         sat  = hi || quo_ff[FRAC_W-1];
         quot = sat ? FRAC_MAX : frac_type'(quo_ff[FRAC_W-1:0]);
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end
endmodule

// ----- rtl/nlau_back.sv -----
module nlau_back #(
   parameter int MAX_POINTS = nlau_pkg::MAX_POINTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   input  nlau_pkg::cmd_type                  cmd,
   output logic                               cmd_pop,
   input  logic [$clog2(MAX_POINTS + 1)-1:0]  slew_n,
   input  logic [$clog2(MAX_POINTS + 1)-1:0]  load_n,
   nlau_rsp_if.source                         rsp_chan
);
   import nlau_pkg::*;

   localparam int CNT_W    = $clog2(MAX_POINTS + 1);
   localparam int CNT1_W   = CNT_W + 1;
   localparam int IDX_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int AX_AW    = SURF_W + IDX_W;
   localparam int GR_AW    = SURF_W + 2 * IDX_W;
   localparam int AX_DEPTH = 1 << AX_AW;
   localparam int GR_DEPTH = 1 << GR_AW;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SRCH_CHK = 4'd1;
   localparam logic [3:0] S_SRCH_CMP = 4'd2;
   localparam logic [3:0] S_AX_RD0   = 4'd3;
   localparam logic [3:0] S_AX_RD1   = 4'd4;
   localparam logic [3:0] S_DIV_GO   = 4'd5;
   localparam logic [3:0] S_DIV_WAIT = 4'd6;
   localparam logic [3:0] S_GRD_RD   = 4'd7;
   localparam logic [3:0] S_BL_SUB   = 4'd8;
   localparam logic [3:0] S_BL_MUL   = 4'd9;
   localparam logic [3:0] S_BL_ADD   = 4'd10;
   localparam logic [3:0] S_APPLY    = 4'd11;
   localparam logic [3:0] S_ACC      = 4'd12;
   localparam logic [3:0] S_DONE     = 4'd13;

   logic [3:0]               state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic                     neg_ff, neg_in;
   logic [SURF_W-1:0]        surf_ff, surf_in;
   logic                     dim_ff, dim_in;
   logic [CNT_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         s_ff, s_in, l_ff, l_in;
   val_type                  a0_ff, a0_in;
   frac_type                 sf_ff, sf_in, lf_ff, lf_in;
   logic [2:0]               gi_ff, gi_in;
   val_type                  g_ff [4];
   val_type                  g_in [4];
   val_type                  p0_ff, p0_in, p1_ff, p1_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]               bsel_ff, bsel_in;
   val_type                  look_ff, look_in, val_ff, val_in;
   val_type                  acc_ff [NUM_SURF];
   val_type                  acc_in [NUM_SURF];
   logic                     sat_ff, sat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [VALUE_WIDTH-1:0]   slew_rdata, load_rdata, grid_rdata;
   logic                     slew_we, load_we, grid_we;
   logic [AX_AW-1:0]         ax_waddr, ld_waddr, ax_raddr;
   logic [GR_AW-1:0]         gr_waddr, gr_raddr;
   logic [IDX_W-1:0]         base_idx, ax_idx, g_row, g_col;

   val_type                  slew_key, load_key, key, arr_sel, ax_rd, v0_sel, v1_sel;
   frac_type                 frac_sel, frac_val;
   logic [CNT_W-1:0]         n_sel;
   logic signed [DIFF_W-1:0] span, dkey;
   logic [DIFF_W-1:0]        abs_span, abs_dkey;
   logic signed [WIDE_W-1:0] wide_sum;
   logic                     sflag, frac_ok;
   val_type                  sval;

   logic                     div_start, div_done, div_sat;
   frac_type                 div_quot;

   assign slew_key = (surf_ff[0] ^ neg_ff) ? cmd_ff.slew_fall : cmd_ff.slew_rise;
   assign load_key = surf_ff[0] ? cmd_ff.load_fall : cmd_ff.load_rise;
   assign arr_sel  = (surf_ff[0] ^ neg_ff) ? cmd_ff.arr_fall : cmd_ff.arr_rise;
   assign key      = dim_ff ? load_key : slew_key;
   assign n_sel    = dim_ff ? load_n : slew_n;
   assign ax_rd    = dim_ff ? val_type'(load_rdata) : val_type'(slew_rdata);
   assign base_idx = dim_ff ? l_ff : s_ff;

   always_comb begin
      case (state_ff)
         S_SRCH_CHK: ax_idx = i_ff[IDX_W-1:0];
         S_AX_RD1:   ax_idx = base_idx + IDX_W'(1);
         default:    ax_idx = base_idx;
      endcase
   end

   assign ax_raddr = {surf_ff, ax_idx};
   assign g_row    = s_ff + IDX_W'(gi_ff[1]);
   assign g_col    = l_ff + IDX_W'(gi_ff[0]);
   assign gr_raddr = {surf_ff, g_row, g_col};

   assign cmd_pop  = (state_ff == S_IDLE) && cmd_valid;
   assign slew_we  = cmd_pop && (cmd.op == OP_WR_SLEW);
   assign load_we  = cmd_pop && (cmd.op == OP_WR_LOAD);
   assign grid_we  = cmd_pop && (cmd.op == OP_WR_GRID);
   assign ax_waddr = {cmd.surf, IDX_W'(cmd.row)};
   assign ld_waddr = {cmd.surf, IDX_W'(cmd.col)};
   assign gr_waddr = {cmd.surf, IDX_W'(cmd.row), IDX_W'(cmd.col)};

   always_comb begin
      case (bsel_ff)
         2'd0: begin
            v0_sel = g_ff[0];
            v1_sel = g_ff[1];
            frac_sel = lf_ff;
         end
         2'd1: begin
            v0_sel = g_ff[2];
            v1_sel = g_ff[3];
            frac_sel = lf_ff;
         end
         default: begin
            v0_sel = p0_ff;
            v1_sel = p1_ff;
            frac_sel = sf_ff;
         end
      endcase
   end

   assign span     = ax_rd - a0_ff;
   assign dkey     = key - a0_ff;
   assign abs_span = span[DIFF_W-1] ? DIFF_W'(-span) : DIFF_W'(span);
   assign abs_dkey = dkey[DIFF_W-1] ? DIFF_W'(-dkey) : DIFF_W'(dkey);

   nlau_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(AX_DEPTH)) u_slew_ram (
      .clock (clock), .we (slew_we), .waddr (ax_waddr), .wdata (cmd.wval),
      .raddr (ax_raddr), .rdata (slew_rdata));

   nlau_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(AX_DEPTH)) u_load_ram (
      .clock (clock), .we (load_we), .waddr (ld_waddr), .wdata (cmd.wval),
      .raddr (ax_raddr), .rdata (load_rdata));

   nlau_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(GR_DEPTH)) u_grid_ram (
      .clock (clock), .we (grid_we), .waddr (gr_waddr), .wdata (cmd.wval),
      .raddr (gr_raddr), .rdata (grid_rdata));

   nlau_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .neg     (dkey[DIFF_W-1] ^ span[DIFF_W-1]),
      .num_mag ({abs_dkey, {FRAC_SHIFT{1'b0}}}),
      .den_mag (abs_span),
      .done    (div_done),
      .quot    (div_quot),
      .sat     (div_sat));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      neg_in       = neg_ff;
      surf_in      = surf_ff;
      dim_in       = dim_ff;
      i_in         = i_ff;
      s_in         = s_ff;
      l_in         = l_ff;
      a0_in        = a0_ff;
      sf_in        = sf_ff;
      lf_in        = lf_ff;
      gi_in        = gi_ff;
      g_in         = g_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      bsel_in      = bsel_ff;
      look_in      = look_ff;
      val_in       = val_ff;
      acc_in       = acc_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      frac_ok      = 1'b0;
      frac_val     = '0;
      wide_sum     = '0;
      {sflag, sval} = sat_wide(wide_sum);

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in  = cmd;
               sat_in  = 1'b0;
               neg_in  = cmd.sense == SENSE_NEG;
               surf_in = '0;
               dim_in  = 1'b0;
               i_in    = CNT_W'(1);
               state_in = S_DONE;
               if (cmd.op == OP_START) begin
                  for (int k = 0; k < NUM_SURF; k++) begin
                     acc_in[k] = '0;
                  end
               end
               if (cmd.op == OP_EVAL) begin
                  state_in = S_SRCH_CHK;
               end
            end
         end
         S_SRCH_CHK: begin
            if (CNT1_W'(i_ff) + CNT1_W'(1) >= CNT1_W'(n_sel)) begin
               if (dim_ff) l_in = IDX_W'(i_ff - CNT_W'(1));
               else        s_in = IDX_W'(i_ff - CNT_W'(1));
               state_in = S_AX_RD0;
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (ax_rd > key) begin
               if (dim_ff) l_in = IDX_W'(i_ff - CNT_W'(1));
               else        s_in = IDX_W'(i_ff - CNT_W'(1));
               state_in = S_AX_RD0;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = S_SRCH_CHK;
            end
         end
         S_AX_RD0: begin
            state_in = S_AX_RD1;
         end
         S_AX_RD1: begin
            a0_in    = ax_rd;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            if (span == '0) begin
               frac_ok = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               frac_ok  = 1'b1;
               frac_val = div_quot;
               if (div_sat) sat_in = 1'b1;
            end
         end
         S_GRD_RD: begin
            if (gi_ff != 3'd0) begin
               g_in[gi_ff[1:0] - 2'd1] = val_type'(grid_rdata);
            end
            if (gi_ff == 3'd4) begin
               bsel_in  = 2'd0;
               state_in = S_BL_SUB;
            end else begin
               gi_in = gi_ff + 3'd1;
            end
         end
         S_BL_SUB: begin
            diff_in  = v1_sel - v0_sel;
            state_in = S_BL_MUL;
         end
         S_BL_MUL: begin
            prod_in  = frac_sel * diff_ff;
            state_in = S_BL_ADD;
         end
         S_BL_ADD: begin
            wide_sum = WIDE_W'(v0_sel) + WIDE_W'(prod_ff >>> FRAC_SHIFT);
            {sflag, sval} = sat_wide(wide_sum);
            if (sflag) sat_in = 1'b1;
            case (bsel_ff)
               2'd0:    p0_in = sval;
               2'd1:    p1_in = sval;
               default: look_in = sval;
            endcase
            if (bsel_ff == 2'd2) begin
               state_in = S_APPLY;
            end else begin
               bsel_in  = bsel_ff + 2'd1;
               state_in = S_BL_SUB;
            end
         end
         S_APPLY: begin
            if (surf_ff[1] == 1'b0) begin
               wide_sum = WIDE_W'(arr_sel) + WIDE_W'(look_ff);
               {sflag, sval} = sat_wide(wide_sum);
               if (sflag) sat_in = 1'b1;
               val_in = sval;
            end else begin
               val_in = look_ff;
            end
            state_in = S_ACC;
         end
         S_ACC: begin
            if (val_ff > acc_ff[surf_ff]) begin
               acc_in[surf_ff] = val_ff;
            end
            dim_in = 1'b0;
            i_in   = CNT_W'(1);
            if (surf_ff == SURF_W'(NUM_SURF - 1)) begin
               surf_in = '0;
               if (!neg_ff && (cmd_ff.sense == SENSE_NON)) begin
                  neg_in   = 1'b1;
                  state_in = S_SRCH_CHK;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               surf_in  = surf_ff + SURF_W'(1);
               state_in = S_SRCH_CHK;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in.arr_rise  = acc_ff[0];
               rsp_in.arr_fall  = acc_ff[1];
               rsp_in.slew_rise = acc_ff[2];
               rsp_in.slew_fall = acc_ff[3];
               rsp_in.sat       = sat_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (frac_ok) begin
         if (dim_ff) begin
            lf_in    = frac_val;
            gi_in    = 3'd0;
            state_in = S_GRD_RD;
         end else begin
            sf_in    = frac_val;
            dim_in   = 1'b1;
            i_in     = CNT_W'(1);
            state_in = S_SRCH_CHK;
         end
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.arrival_out_rise = rsp_ff.arr_rise;
   assign rsp_chan.arrival_out_fall = rsp_ff.arr_fall;
   assign rsp_chan.slew_out_rise    = rsp_ff.slew_rise;
   assign rsp_chan.slew_out_fall    = rsp_ff.slew_fall;
   assign rsp_chan.saturated        = rsp_ff.sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NUM_SURF; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      neg_ff  <= neg_in;
      surf_ff <= surf_in;
      dim_ff  <= dim_in;
      i_ff    <= i_in;
      s_ff    <= s_in;
      l_ff    <= l_in;
      a0_ff   <= a0_in;
      sf_ff   <= sf_in;
      lf_ff   <= lf_in;
      gi_ff   <= gi_in;
      g_ff    <= g_in;
      p0_ff   <= p0_in;
      p1_ff   <= p1_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
      bsel_ff <= bsel_in;
      look_ff <= look_in;
      val_ff  <= val_in;
      sat_ff  <= sat_in;
      rsp_ff  <= rsp_in;
   end
endmodule

// ----- rtl/nldm_arc_arrival_update.sv -----
// Arc arrival update over four bilinear delay tables (cell rise, cell fall, rise and fall
// transition). Every beat on req_chan gives exactly one beat on rsp_chan carrying the four
// accumulators after it. A two-entry queue sits behind req_chan, so up to two beats are taken
// while a lookup runs or a response waits. An evaluate runs four lookups (eight for
// non-unate) one after another; each lookup runs an axis search, axis reads and a fraction
// divide first on the slew axis and then on the load axis, then the grid reads, the three
// blends and the accumulate. The fraction divider yields one quotient bit per cycle.
module nldm_arc_arrival_update #(
   parameter int MAX_POINTS = nlau_pkg::MAX_POINTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   nlau_req_if.sink    req_chan,
   nlau_rsp_if.source  rsp_chan,
   nlau_csr_if.sink    csr_chan
);
   import nlau_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic [CNT_FIELD_W-1:0] slew_pts_ff, slew_pts_in, load_pts_ff, load_pts_in;
   logic [CNT_W-1:0]       slew_n, load_n;
   logic                   cmd_valid, cmd_pop;
   cmd_type                cmd;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      slew_pts_in = slew_pts_ff;
      load_pts_in = load_pts_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_SLEW_POINTS: slew_pts_in = csr_chan.data;
            CSR_LOAD_POINTS: load_pts_in = csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (int'(slew_pts_ff) < PTS_MIN)         slew_n = CNT_W'(PTS_MIN);
      else if (int'(slew_pts_ff) > MAX_POINTS) slew_n = CNT_W'(MAX_POINTS);
      else                                     slew_n = CNT_W'(slew_pts_ff);
      if (int'(load_pts_ff) < PTS_MIN)         load_n = CNT_W'(PTS_MIN);
      else if (int'(load_pts_ff) > MAX_POINTS) load_n = CNT_W'(MAX_POINTS);
      else                                     load_n = CNT_W'(load_pts_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_pts_ff <= PTS_RESET;
         load_pts_ff <= PTS_RESET;
      end else begin
         slew_pts_ff <= slew_pts_in;
         load_pts_ff <= load_pts_in;
      end
   end

   nlau_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop));

   nlau_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .slew_n    (slew_n),
      .load_n    (load_n),
      .rsp_chan  (rsp_chan));
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import nlau_pkg::*;

   localparam logic [REQ_W-1:0]   REQ_SPARE_LO = 3'd5;
   localparam logic [REQ_W-1:0]   REQ_SPARE_HI = 3'd7;
   localparam logic [SENSE_W-1:0] SENSE_NONE   = 2'd3;
   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 6000000;

   typedef struct {
      logic [REQ_W-1:0]       kind;
      logic [SURF_W-1:0]      surf;
      logic [IDX_FIELD_W-1:0] row;
      logic [IDX_FIELD_W-1:0] col;
      val_type                wval;
      logic [SENSE_W-1:0]     sense;
      val_type                arr_r, arr_f, slew_r, slew_f, load_r, load_f;
   } arc_beat_t;

   typedef struct {
      val_type arr_r, arr_f, slew_r, slew_f;
      logic    sat;
   } timing_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nlau_req_if req_bus ();
   nlau_rsp_if rsp_bus ();
   nlau_csr_if csr_bus ();

   nldm_arc_arrival_update uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #4 clock = ~clock;

   arc_beat_t pending_beats[$];
   timing_t   expected_timing[$];
   int        errors = 0;
   int        cycles = 0;

   int slew_tab[4][8];
   int load_tab[4][8];
   int grid_tab[4][8][8];
   logic [CNT_FIELD_W-1:0] slew_pts_reg = PTS_RESET;
   logic [CNT_FIELD_W-1:0] load_pts_reg = PTS_RESET;
   longint acc_ar = 0, acc_af = 0, acc_sr = 0, acc_sf = 0;
   bit sat_hit;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic int eff_pts(input logic [CNT_FIELD_W-1:0] n);
      if (n < PTS_MIN) return PTS_MIN;
      if (n > 8) return 8;
      return n;
   endfunction

   function automatic longint clamp_val(input longint v);
      if (v > VMAX) begin
         sat_hit = 1;
         return VMAX;
      end
      if (v < VMIN) begin
         sat_hit = 1;
         return VMIN;
      end
      return v;
   endfunction

   function automatic int seg_of(input bit is_load, input int surf, input int n, input longint key);
      int i;
      for (i = 1; i + 1 < n; i++) begin
         if ((is_load ? load_tab[surf][i] : slew_tab[surf][i]) > key) break;
      end
      return i - 1;
   endfunction

   function automatic longint frac_of(input longint key, input longint a0, input longint a1);
      longint span, q;
      span = a1 - a0;
      if (span == 0) return 0;
      q = ((key - a0) * 65536) / span;
      return clamp_val(q);
   endfunction

   function automatic longint blend(input longint v0, input longint v1, input longint fr);
      longint p;
      p = fr * (v1 - v0);
      return clamp_val(v0 + (p >>> 16));
   endfunction

   function automatic longint table_delay(input int surf, input longint slew, input longint load);
      int s, l;
      longint sf, lf, p0, p1;
      s = seg_of(0, surf, eff_pts(slew_pts_reg), slew);
      l = seg_of(1, surf, eff_pts(load_pts_reg), load);
      sf = frac_of(slew, slew_tab[surf][s], slew_tab[surf][s+1]);
      lf = frac_of(load, load_tab[surf][l], load_tab[surf][l+1]);
      p0 = blend(grid_tab[surf][s][l], grid_tab[surf][s][l+1], lf);
      p1 = blend(grid_tab[surf][s+1][l], grid_tab[surf][s+1][l+1], lf);
      return blend(p0, p1, sf);
   endfunction

   function automatic void keep_max(ref longint acc, input longint v);
      if (v > acc) acc = v;
   endfunction

   function automatic timing_t update_arrival(input arc_beat_t b);
      timing_t r;
      sat_hit = 0;
      case (b.kind)
         REQ_WR_SLEW: slew_tab[b.surf][b.row] = b.wval;
         REQ_WR_LOAD: load_tab[b.surf][b.col] = b.wval;
         REQ_WR_GRID: grid_tab[b.surf][b.row][b.col] = b.wval;
         REQ_START: begin
            acc_ar = 0; acc_af = 0; acc_sr = 0; acc_sf = 0;
         end
         REQ_EVAL: begin
            if (b.sense == SENSE_POS || b.sense == SENSE_NON) begin
               keep_max(acc_ar, clamp_val(b.arr_r + table_delay(0, b.slew_r, b.load_r)));
               keep_max(acc_af, clamp_val(b.arr_f + table_delay(1, b.slew_f, b.load_f)));
               keep_max(acc_sr, table_delay(2, b.slew_r, b.load_r));
               keep_max(acc_sf, table_delay(3, b.slew_f, b.load_f));
            end
            if (b.sense == SENSE_NEG || b.sense == SENSE_NON) begin
               keep_max(acc_ar, clamp_val(b.arr_f + table_delay(0, b.slew_f, b.load_r)));
               keep_max(acc_af, clamp_val(b.arr_r + table_delay(1, b.slew_r, b.load_f)));
               keep_max(acc_sr, table_delay(2, b.slew_f, b.load_r));
               keep_max(acc_sf, table_delay(3, b.slew_r, b.load_f));
            end
         end
         default: ;
      endcase
      r.arr_r = acc_ar[31:0];
      r.arr_f = acc_af[31:0];
      r.slew_r = acc_sr[31:0];
      r.slew_f = acc_sf[31:0];
      r.sat = sat_hit;
      return r;
   endfunction

   // values: mostly within +-span units of Q16.16, sometimes full range or an extreme
   function automatic val_type pick_val(input int span);
      case ($urandom_range(0, 11))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? val_type'(VMAX) : val_type'(VMIN);
         default: return ((int'($urandom_range(0, 2 * span)) - span) <<< 16) + $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic val_type axis_val(input int idx);
      if ($urandom_range(0, 15) == 0) return pick_val(200);
      return ((idx * 8 + int'($urandom_range(0, 6)) - 3) <<< 16) + $urandom_range(0, 65535);
   endfunction

   function automatic arc_beat_t blank_beat(input logic [REQ_W-1:0] kind);
      arc_beat_t b;
      b.kind = kind;
      b.surf = $urandom;
      b.row = $urandom;
      b.col = $urandom;
      b.wval = $urandom;
      b.sense = $urandom_range(0, 2);
      b.arr_r = pick_val(1000);
      b.arr_f = pick_val(1000);
      b.slew_r = pick_val(40) + (24 <<< 16);
      b.slew_f = pick_val(40) + (24 <<< 16);
      b.load_r = pick_val(40) + (24 <<< 16);
      b.load_f = pick_val(40) + (24 <<< 16);
      return b;
   endfunction

   function automatic arc_beat_t table_write(input logic [REQ_W-1:0] kind, input int surf,
                                             input int row, input int col);
      arc_beat_t b;
      b = blank_beat(kind);
      b.surf = surf;
      b.row = row;
      b.col = col;
      if (kind == REQ_WR_SLEW) b.wval = axis_val(row);
      else if (kind == REQ_WR_LOAD) b.wval = axis_val(col);
      else b.wval = pick_val(64);
      return b;
   endfunction

   function automatic arc_beat_t random_beat();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return blank_beat(REQ_EVAL);
      if (pick < 48) return blank_beat(REQ_START);
      if (pick < 56) return table_write(REQ_WR_SLEW, $urandom_range(0, 3), $urandom_range(0, 7), 0);
      if (pick < 64) return table_write(REQ_WR_LOAD, $urandom_range(0, 3), 0, $urandom_range(0, 7));
      if (pick < 92) begin
         return table_write(REQ_WR_GRID, $urandom_range(0, 3), $urandom_range(0, 7),
                            $urandom_range(0, 7));
      end
      if (pick < 96) return blank_beat($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      begin
         arc_beat_t b;
         b = blank_beat(REQ_EVAL);
         b.sense = SENSE_NONE;
         return b;
      end
   endfunction

   // driver: bursts of random length with random gaps
   arc_beat_t cur_beat;
   int burst_left = 0, gap_left = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.req_type = '0;
      req_bus.surface_sel = '0;
      req_bus.row = '0;
      req_bus.col = '0;
      req_bus.write_value = '0;
      req_bus.arc_sense = '0;
      req_bus.arrival_in_rise = '0;
      req_bus.arrival_in_fall = '0;
      req_bus.slew_in_rise = '0;
      req_bus.slew_in_fall = '0;
      req_bus.load_rise = '0;
      req_bus.load_fall = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = '0;
      csr_bus.data = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) expected_timing.push_back(update_arrival(cur_beat));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
               cur_beat = pending_beats.pop_front();
               req_bus.valid <= 1'b1;
               req_bus.req_type <= cur_beat.kind;
               req_bus.surface_sel <= cur_beat.surf;
               req_bus.row <= cur_beat.row;
               req_bus.col <= cur_beat.col;
               req_bus.write_value <= cur_beat.wval;
               req_bus.arc_sense <= cur_beat.sense;
               req_bus.arrival_in_rise <= cur_beat.arr_r;
               req_bus.arrival_in_fall <= cur_beat.arr_f;
               req_bus.slew_in_rise <= cur_beat.slew_r;
               req_bus.slew_in_fall <= cur_beat.slew_f;
               req_bus.load_rise <= cur_beat.load_r;
               req_bus.load_fall <= cur_beat.load_f;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: receiver stall pattern steps through four modes
   always @(posedge clock) begin
      timing_t e;
      int mode;
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** nldm_arc_arrival_update: FAILED **");
         $finish;
      end else if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_timing.size() == 0) begin
               report("unexpected beat", 0, 0);
            end else begin
               e = expected_timing.pop_front();
               if (rsp_bus.arrival_out_rise !== e.arr_r)
                  report("arrival_out_rise", rsp_bus.arrival_out_rise, e.arr_r);
               if (rsp_bus.arrival_out_fall !== e.arr_f)
                  report("arrival_out_fall", rsp_bus.arrival_out_fall, e.arr_f);
               if (rsp_bus.slew_out_rise !== e.slew_r)
                  report("slew_out_rise", rsp_bus.slew_out_rise, e.slew_r);
               if (rsp_bus.slew_out_fall !== e.slew_f)
                  report("slew_out_fall", rsp_bus.slew_out_fall, e.slew_f);
               if (rsp_bus.saturated !== e.sat)
                  report("saturated", rsp_bus.saturated, e.sat);
            end
         end
         mode = (cycles / 600) % 4;
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= ((cycles % 9) < 3);
            default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   task automatic drain();
      while (pending_beats.size() > 0 || req_bus.valid || expected_timing.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CNT_FIELD_W-1:0] val);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.addr <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_SLEW_POINTS) slew_pts_reg = val;
      else load_pts_reg = val;
   endtask

   task automatic random_phase(input logic [CNT_FIELD_W-1:0] ns, input logic [CNT_FIELD_W-1:0] nl,
                               input int count);
      drain();
      csr_write(CSR_SLEW_POINTS, ns);
      csr_write(CSR_LOAD_POINTS, nl);
      repeat (count) pending_beats.push_back(random_beat());
   endtask

   initial begin
      arc_beat_t b;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      csr_write(CSR_SLEW_POINTS, 4'd8);
      csr_write(CSR_LOAD_POINTS, 4'd8);
      // fill every table entry before any lookup
      for (int s = 0; s < 4; s++) begin
         for (int i = 0; i < 8; i++) begin
            pending_beats.push_back(table_write(REQ_WR_SLEW, s, i, 0));
            pending_beats.push_back(table_write(REQ_WR_LOAD, s, 0, i));
            for (int j = 0; j < 8; j++) pending_beats.push_back(table_write(REQ_WR_GRID, s, i, j));
         end
      end
      for (int k = 0; k < 3; k++) begin
         b = blank_beat(REQ_EVAL);
         b.sense = k;
         pending_beats.push_back(b);
      end
      b = blank_beat(REQ_EVAL);
      b.sense = SENSE_NONE;
      pending_beats.push_back(b);
      for (int k = REQ_SPARE_LO; k <= REQ_SPARE_HI; k++) pending_beats.push_back(blank_beat(k));
      // extremes of keys and arrivals
      b = blank_beat(REQ_EVAL);
      b.sense = SENSE_NON;
      b.slew_r = val_type'(VMAX); b.slew_f = val_type'(VMIN);
      b.load_r = val_type'(VMIN); b.load_f = val_type'(VMAX);
      b.arr_r = val_type'(VMAX); b.arr_f = val_type'(VMIN);
      pending_beats.push_back(b);
      pending_beats.push_back(blank_beat(REQ_START));
      b.arr_r = val_type'(VMIN); b.arr_f = val_type'(VMAX);
      b.slew_r = 0; b.slew_f = 0; b.load_r = 0; b.load_f = 0;
      pending_beats.push_back(b);
      // extreme grid values
      b = table_write(REQ_WR_GRID, 0, 0, 0); b.wval = val_type'(VMAX); pending_beats.push_back(b);
      b = table_write(REQ_WR_GRID, 0, 0, 1); b.wval = val_type'(VMIN); pending_beats.push_back(b);
      // zero span on the first slew segment of every surface
      for (int s = 0; s < 4; s++) begin
         b = table_write(REQ_WR_SLEW, s, 0, 0); b.wval = 32'sd65536; pending_beats.push_back(b);
         b = table_write(REQ_WR_SLEW, s, 1, 0); b.wval = 32'sd65536; pending_beats.push_back(b);
      end
      b = blank_beat(REQ_EVAL);
      b.sense = SENSE_NON;
      b.slew_r = 32'sd65536; b.slew_f = -32'sd65536;
      b.load_r = 0; b.load_f = 3 <<< 16;
      pending_beats.push_back(b);
      pending_beats.push_back(blank_beat(REQ_START));

      random_phase(4'd8, 4'd8, 170);
      random_phase(4'd2, 4'd2, 100);
      random_phase(4'd0, 4'd15, 100);
      random_phase(4'd15, 4'd1, 100);
      random_phase(4'd5, 4'd3, 100);
      random_phase($urandom_range(0, 15), $urandom_range(0, 15), 140);
      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("** nldm_arc_arrival_update: PASSED **");
      end else begin
         $display("** nldm_arc_arrival_update: FAILED **");
      end
      $finish;
   end

endmodule
